### rtl/core/ohlc_pkg.sv
// Package for the OHLCV bar aggregator: payload structs, command and state types,
// widths and constants. No dependencies.
package ohlc_pkg;

   localparam int TIME_W   = 48;
   localparam int PRICE_W  = 32;
   localparam int VOL_W    = 48;
   localparam int QUOTE_W  = 64;
   localparam int TF_W     = 17;
   localparam int PERIOD_W = 27;
   localparam int DIVD_W   = 64;
   localparam int DIVS_W   = 48;

   localparam int FILL_LIMIT = 62;
   localparam int FILL_CAP   = (FILL_LIMIT > 62) ? 62 : FILL_LIMIT;
   localparam int FILL_W     = 6;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PERIOD_W-1:0] MS_PER_S = PERIOD_W'(1000);

   typedef struct packed {
      logic [47:0] trade_time;
      logic [31:0] price;
      logic [31:0] volume;
      logic [47:0] quote;
      logic        buyer_is_maker;
   } req_type;

   typedef struct packed {
      logic [47:0] bar_time;
      logic [31:0] open_price;
      logic [31:0] high_price;
      logic [31:0] low_price;
      logic [31:0] close_price;
      logic [31:0] vwap_price;
      logic [31:0] trade_count;
      logic [47:0] volume_total;
      logic [47:0] volume_buy;
      logic [63:0] quote_total;
      logic [63:0] quote_buy;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_OPEN,
      CMD_INBAR,
      CMD_CLOSE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      req_type             trade;
      logic [FILL_W-1:0]   fill;
      logic [TIME_W-1:0]   bar_time;
      logic [PERIOD_W-1:0] period;
   } cmd_type;

   typedef enum logic [2:0] {
      FE_IDLE,
      FE_EVAL,
      FE_FILL_DIV,
      FE_ALIGN_DIV,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_VWAP,
      BK_BAR,
      BK_FILL
   } bk_state_type;

endpackage

### rtl/core/ohlc_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 48-bit divisor.
// Depends on ohlc_pkg.
module ohlc_div
   import ohlc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient,
   output logic [DIVS_W-1:0] remainder
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [$clog2(DIVD_W)-1:0]     cnt_ff, cnt_in;
   logic [DIVD_W-1:0]             quo_ff, quo_in;
   logic [DIVS_W-1:0]             rem_ff, rem_in;
   logic [DIVS_W-1:0]             dsr_ff, dsr_in;
   logic [DIVS_W:0]               trial;
   logic [DIVS_W:0]               diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (busy_ff) begin
         // shift one dividend bit in, subtract when it fits
         quo_in = {quo_ff[DIVD_W-2:0], ~diff[DIVS_W]};
         rem_in = diff[DIVS_W] ? trial[DIVS_W-1:0] : diff[DIVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### rtl/core/ohlc_front.sv
// Front end: accepts trades, drops stale ones, finds bar boundaries and fill
// counts, and pushes commands to the queue. Depends on ohlc_pkg and ohlc_div.
module ohlc_front
   import ohlc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   input  logic [TF_W-1:0] timeframe,
   output logic            push,
   output cmd_type         push_cmd,
   input  logic            queue_full
);

   fe_state_type        state_ff, state_in;
   req_type             trade_ff, trade_in;
   logic [TIME_W-1:0]   last_seen_ff, last_seen_in;
   logic [TIME_W-1:0]   cur_bar_ff, cur_bar_in;
   logic                bar_open_ff, bar_open_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   cmd_kind_type        kind_ff, kind_in;

   logic                div_start;
   logic                div_done;
   logic [DIVD_W-1:0]   div_dividend;
   logic [DIVD_W-1:0]   div_quo;
   logic [DIVS_W-1:0]   div_rem;
   logic [TIME_W-1:0]   span;
   logic [DIVD_W-1:0]   quo_m1;
   logic [TF_W-1:0]     tf_eff;

   ohlc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (DIVS_W'(period_ff)),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      tf_eff        = (timeframe == '0) ? TF_W'(1) : timeframe;
      span          = trade_ff.trade_time - cur_bar_ff;
      quo_m1        = div_quo - DIVD_W'(1);
      state_in      = state_ff;
      trade_in      = trade_ff;
      last_seen_in  = last_seen_ff;
      cur_bar_in    = cur_bar_ff;
      bar_open_in   = bar_open_ff;
      period_in     = period_ff;
      fill_in       = fill_ff;
      kind_in       = kind_ff;
      div_start     = 1'b0;
      div_dividend  = DIVD_W'(trade_ff.trade_time);
      req_ready     = 1'b0;
      push          = 1'b0;
      case (state_ff)
         FE_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               trade_in  = req_data;
               period_in = PERIOD_W'(tf_eff) * MS_PER_S;
               state_in  = FE_EVAL;
            end
         end
         FE_EVAL: begin
            if (trade_ff.trade_time < last_seen_ff) begin
               state_in = FE_IDLE;     // drop: older than last trade
            end else begin
               last_seen_in = trade_ff.trade_time;
               if (!bar_open_ff) begin
                  kind_in   = CMD_OPEN;
                  fill_in   = '0;
                  div_start = 1'b1;
                  state_in  = FE_ALIGN_DIV;
               end else if (trade_ff.trade_time < cur_bar_ff) begin
                  state_in = FE_IDLE;  // drop: before the open bar
               end else if (span < TIME_W'(period_ff)) begin
                  kind_in  = CMD_INBAR;
                  fill_in  = '0;
                  state_in = FE_PUSH;
               end else begin
                  kind_in      = CMD_CLOSE;
                  div_dividend = DIVD_W'(span);
                  div_start    = 1'b1;
                  state_in     = FE_FILL_DIV;
               end
            end
         end
         FE_FILL_DIV: begin
            if (div_done) begin
               fill_in   = (quo_m1 > DIVD_W'(FILL_CAP)) ? FILL_W'(FILL_CAP)
                                                        : quo_m1[FILL_W-1:0];
               div_start = 1'b1;
               state_in  = FE_ALIGN_DIV;
            end
         end
         FE_ALIGN_DIV: begin
            if (div_done) begin
               cur_bar_in  = trade_ff.trade_time - div_rem;
               bar_open_in = 1'b1;
               state_in    = FE_PUSH;
            end
         end
         FE_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = FE_IDLE;
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

   always_comb begin
      push_cmd.kind     = kind_ff;
      push_cmd.trade    = trade_ff;
      push_cmd.fill     = fill_ff;
      push_cmd.bar_time = cur_bar_ff;
      push_cmd.period   = period_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FE_IDLE;
         last_seen_ff <= '0;
         cur_bar_ff   <= '0;
         bar_open_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_seen_ff <= last_seen_in;
         cur_bar_ff   <= cur_bar_in;
         bar_open_ff  <= bar_open_in;
      end
      trade_ff  <= trade_in;
      period_ff <= period_in;
      fill_ff   <= fill_in;
      kind_ff   <= kind_in;
   end

   a_push_has_bar: assert property (@(posedge clock) disable iff (reset)
      push |-> bar_open_ff)
      else $error("command pushed with no open bar");

endmodule

### rtl/core/ohlc_queue.sv
// Short command queue between front and back end, held in registers.
// Depends on ohlc_pkg.
module ohlc_queue
   import ohlc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
      empty = (cnt_ff == '0);
      head  = slot_ff[rd_ff];
      wr_in = push ? next_ptr(wr_ff) : wr_ff;
      rd_in = pop ? next_ptr(rd_ff) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

### rtl/core/ohlc_back.sv
// Back end: keeps the open bar, computes VWAP on close, emits the bar and its
// fillers through the output register. Depends on ohlc_pkg and ohlc_div.
module ohlc_back
   import ohlc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    empty,
   input  cmd_type head,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   bk_state_type       state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [TIME_W-1:0]  bar_time_ff, bar_time_in;
   logic [PRICE_W-1:0] open_ff, open_in, high_ff, high_in, low_ff, low_in;
   logic [PRICE_W-1:0] close_ff, close_in, vwap_ff, vwap_in;
   logic [31:0]        count_ff, count_in;
   logic [VOL_W-1:0]   vt_ff, vt_in, vb_ff, vb_in;
   logic [QUOTE_W-1:0] qt_ff, qt_in, qb_ff, qb_in;
   logic               avg_ff, avg_in;
   logic [FILL_W-1:0]  k_ff, k_in;
   logic [TIME_W-1:0]  ftime_ff, ftime_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;

   logic               div_start;
   logic               div_done;
   logic [DIVD_W-1:0]  div_quo;
   logic [DIVS_W-1:0]  div_rem;
   logic               out_free;
   logic               do_open;
   cmd_type            open_src;
   logic [VOL_W:0]     vt_sum, vb_sum;
   logic [QUOTE_W:0]   qt_sum, qb_sum;
   logic               is_buy;

   ohlc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (qt_ff),
      .divisor   (vt_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      out_free = !out_valid_ff || rsp_ready;
      is_buy   = !head.trade.buyer_is_maker;
      vt_sum   = {1'b0, vt_ff} + (VOL_W + 1)'(head.trade.volume);
      vb_sum   = {1'b0, vb_ff} + (VOL_W + 1)'(head.trade.volume);
      qt_sum   = {1'b0, qt_ff} + (QUOTE_W + 1)'(head.trade.quote);
      qb_sum   = {1'b0, qb_ff} + (QUOTE_W + 1)'(head.trade.quote);

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      bar_time_in  = bar_time_ff;
      open_in      = open_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      close_in     = close_ff;
      vwap_in      = vwap_ff;
      count_in     = count_ff;
      vt_in        = vt_ff;
      vb_in        = vb_ff;
      qt_in        = qt_ff;
      qb_in        = qb_ff;
      avg_in       = avg_ff;
      k_in         = k_ff;
      ftime_in     = ftime_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      pop          = 1'b0;
      div_start    = 1'b0;
      do_open      = 1'b0;
      open_src     = cmd_ff;

      case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               cmd_in = head;
               case (head.kind)
                  CMD_OPEN: begin
                     do_open  = 1'b1;
                     open_src = head;
                  end
                  CMD_INBAR: begin
                     if (head.trade.price > high_ff) high_in = head.trade.price;
                     if (head.trade.price < low_ff) low_in = head.trade.price;
                     close_in = head.trade.price;
                     count_in = (&count_ff) ? count_ff : count_ff + 1'b1;
                     vt_in    = vt_sum[VOL_W] ? '1 : vt_sum[VOL_W-1:0];
                     qt_in    = qt_sum[QUOTE_W] ? '1 : qt_sum[QUOTE_W-1:0];
                     if (is_buy) begin
                        vb_in = vb_sum[VOL_W] ? '1 : vb_sum[VOL_W-1:0];
                        qb_in = qb_sum[QUOTE_W] ? '1 : qb_sum[QUOTE_W-1:0];
                     end
                     avg_in = 1'b1;
                  end
                  CMD_CLOSE: begin
                     // settle VWAP before the bar goes out
                     if (avg_ff && vt_ff != '0) begin
                        div_start = 1'b1;
                        state_in  = BK_VWAP;
                     end else begin
                        if (avg_ff) vwap_in = '0;
                        state_in = BK_BAR;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_VWAP: begin
            if (div_done) begin
               vwap_in  = (|div_quo[DIVD_W-1:PRICE_W]) ? '1 : div_quo[PRICE_W-1:0];
               state_in = BK_BAR;
            end
         end
         BK_BAR: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.bar_time    = bar_time_ff;
               out_in.open_price  = open_ff;
               out_in.high_price  = high_ff;
               out_in.low_price   = low_ff;
               out_in.close_price = close_ff;
               out_in.vwap_price  = vwap_ff;
               out_in.trade_count = count_ff;
               out_in.volume_total = vt_ff;
               out_in.volume_buy  = vb_ff;
               out_in.quote_total = qt_ff;
               out_in.quote_buy   = qb_ff;
               out_in.last_of_run = (cmd_ff.fill == '0);
               k_in     = FILL_W'(1);
               ftime_in = bar_time_ff + TIME_W'(cmd_ff.period);
               if (cmd_ff.fill == '0) begin
                  do_open  = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  state_in = BK_FILL;
               end
            end
         end
         BK_FILL: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.bar_time    = ftime_ff;
               out_in.open_price  = close_ff;
               out_in.high_price  = close_ff;
               out_in.low_price   = close_ff;
               out_in.close_price = close_ff;
               out_in.vwap_price  = vwap_ff;
               out_in.trade_count = '0;
               out_in.volume_total = '0;
               out_in.volume_buy  = '0;
               out_in.quote_total = '0;
               out_in.quote_buy   = '0;
               out_in.last_of_run = (k_ff == cmd_ff.fill);
               k_in     = k_ff + 1'b1;
               ftime_in = ftime_ff + TIME_W'(cmd_ff.period);
               if (k_ff == cmd_ff.fill) begin
                  do_open  = 1'b1;
                  state_in = BK_IDLE;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase

      if (do_open) begin
         bar_time_in = open_src.bar_time;
         open_in     = open_src.trade.price;
         high_in     = open_src.trade.price;
         low_in      = open_src.trade.price;
         close_in    = open_src.trade.price;
         vwap_in     = open_src.trade.price;
         count_in    = 32'd1;
         vt_in       = VOL_W'(open_src.trade.volume);
         vb_in       = open_src.trade.buyer_is_maker ? '0 : VOL_W'(open_src.trade.volume);
         qt_in       = QUOTE_W'(open_src.trade.quote);
         qb_in       = open_src.trade.buyer_is_maker ? '0 : QUOTE_W'(open_src.trade.quote);
         avg_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         bar_time_ff  <= '0;
         open_ff      <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         close_ff     <= '0;
         vwap_ff      <= '0;
         count_ff     <= '0;
         vt_ff        <= '0;
         vb_ff        <= '0;
         qt_ff        <= '0;
         qb_ff        <= '0;
         avg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         bar_time_ff  <= bar_time_in;
         open_ff      <= open_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         close_ff     <= close_in;
         vwap_ff      <= vwap_in;
         count_ff     <= count_in;
         vt_ff        <= vt_in;
         vb_ff        <= vb_in;
         qt_ff        <= qt_in;
         qb_ff        <= qb_in;
         avg_ff       <= avg_in;
      end
      cmd_ff   <= cmd_in;
      k_ff     <= k_in;
      ftime_ff <= ftime_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FILL) |-> (k_ff != '0 && k_ff <= cmd_ff.fill))
      else $error("filler index out of range");

   a_filler_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FILL && out_free) |=> (rsp_data.trade_count == '0))
      else $error("filler bar carries trades");

endmodule

### rtl/core/trade_to_ohlcv_bar_aggregator_unit.sv
// Top level of the trade to OHLCV bar aggregator: config register, front end,
// command queue and back end. Depends on ohlc_pkg, ohlc_front, ohlc_queue, ohlc_back.
//
// Usage:
//  - req_*: one trade per transfer (valid/ready). rsp_*: one bar per transfer.
//  - csr_*: write channel for the bar length in seconds; always ready. Write it
//    only while idle; the new length applies from the next trade.
//  - A trade inside the open bar goes through accept, classify and push in the front
//    end and is then taken by the back end; the front takes no new trade until it has pushed.
//  - The first trade holds the front while the 64-step divider aligns its time.
//  - A closing trade holds the front for two 64-step divisions (fill count, then
//    alignment); the back end then runs the VWAP division when it needs one and
//    emits one bar per cycle while rsp_ready allows (the bar plus up to 62 fillers).
//  - A 2-entry command queue lets the front classify the next trade while the
//    back end is still emitting bars.
//  - Reset clears the open bar and sets the bar length to 1 s.
//  - When rsp_ready is low the output register holds the bar, the back end
//    stalls, the queue fills, and then req_ready drops.
module trade_to_ohlcv_bar_aggregator_unit
   import ohlc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [TF_W-1:0] csr_data
);

   logic [TF_W-1:0] timeframe_ff, timeframe_in;
   logic            push, pop, full, empty;
   cmd_type         push_cmd, head;

   // take every write; hold the bar length
   assign csr_ready    = 1'b1;
   assign timeframe_in = (csr_valid && csr_ready) ? csr_data : timeframe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeframe_ff <= TF_W'(1);
      end else begin
         timeframe_ff <= timeframe_in;
      end
   end

   ohlc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .timeframe  (timeframe_ff),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (full)
   );

   ohlc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   ohlc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### dv/tb_top.sv
// Testbench for trade_to_ohlcv_bar_aggregator_unit: drives trades, predicts the OHLCV bars
// and checks every bar transfer field by field. Depends on ohlc_pkg and the RTL top level.
module tb_top
   import ohlc_pkg::*;
;

   localparam int HALF_PERIOD    = 5;
   localparam int STALL_LIMIT    = 20000;  // cycles with no transfer before giving up
   localparam int SETTLE_CYCLES  = 400;    // worst close: two front divisions, VWAP, 63 bars
   localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF;
   localparam logic [63:0] M32      = 64'hFFFF_FFFF;
   localparam logic [63:0] M48      = 64'hFFFF_FFFF_FFFF;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_type         req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_type         rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [TF_W-1:0] csr_data = '0;

   trade_to_ohlcv_bar_aggregator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Shadow of the block: configuration and the open bar.
   logic [TF_W-1:0] bar_seconds;
   logic            bar_is_open;
   logic [63:0]     prev_trade_ms;
   logic [63:0]     bar_start;
   logic [31:0]     px_open, px_high, px_low, px_close, px_vwap;
   logic [31:0]     trade_cnt;
   logic [63:0]     vol_total, vol_buy, quote_total, quote_buy;

   rsp_type expected_bars[$];
   int      error_count = 0;

   // Sender and receiver pacing.
   int          burst_left = 0;
   int          hold_request = 0;
   int          hold_left = 0;
   int          ready_phase = 0;
   int          idle_cycles = 0;
   logic [63:0] next_time = '0;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] max);
      logic [64:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return (sum > {1'b0, max}) ? max : sum[63:0];
   endfunction

   function automatic logic [63:0] bar_length_ms();
      return ((bar_seconds == 0) ? 64'd1 : 64'(bar_seconds)) * 64'd1000;
   endfunction

   task automatic start_new_bar(input req_type tr);
      logic [63:0] per;
      per = bar_length_ms();
      bar_start   = tr.trade_time - (tr.trade_time % per);
      px_open     = tr.price;
      px_high     = tr.price;
      px_low      = tr.price;
      px_close    = tr.price;
      px_vwap     = tr.price;
      trade_cnt   = 32'd1;
      vol_total   = 64'(tr.volume);
      vol_buy     = tr.buyer_is_maker ? 64'd0 : 64'(tr.volume);
      quote_total = 64'(tr.quote);
      quote_buy   = tr.buyer_is_maker ? 64'd0 : 64'(tr.quote);
      bar_is_open = 1'b1;
   endtask

   // Update the shadow bar for one accepted trade and queue the bars it closes.
   task automatic predict_bars(input req_type tr);
      logic [63:0] t, per, fill, w;
      rsp_type     b;
      t   = tr.trade_time;
      per = bar_length_ms();
      if (t < prev_trade_ms) return;   // stale trade: drop without a trace
      if (!bar_is_open) begin
         start_new_bar(tr);
      end else if (t < bar_start) begin
         // before the open bar: only the last time moves
      end else if (t - bar_start < per) begin
         if (tr.price > px_high) px_high = tr.price;
         if (tr.price < px_low) px_low = tr.price;
         px_close    = tr.price;
         trade_cnt   = 32'(sat_add(64'(trade_cnt), 64'd1, M32));
         vol_total   = sat_add(vol_total, 64'(tr.volume), M48);
         quote_total = sat_add(quote_total, 64'(tr.quote), '1);
         if (!tr.buyer_is_maker) begin
            vol_buy   = sat_add(vol_buy, 64'(tr.volume), M48);
            quote_buy = sat_add(quote_buy, 64'(tr.quote), '1);
         end
         if (vol_total != 0) begin
            w = quote_total / vol_total;
            px_vwap = (w > M32) ? 32'hFFFF_FFFF : w[31:0];
         end else begin
            px_vwap = '0;
         end
      end else begin
         fill = (t - bar_start) / per - 1;
         if (fill > 64'(FILL_CAP)) fill = 64'(FILL_CAP);
         b.bar_time     = bar_start[47:0];
         b.open_price   = px_open;
         b.high_price   = px_high;
         b.low_price    = px_low;
         b.close_price  = px_close;
         b.vwap_price   = px_vwap;
         b.trade_count  = trade_cnt;
         b.volume_total = vol_total[47:0];
         b.volume_buy   = vol_buy[47:0];
         b.quote_total  = quote_total;
         b.quote_buy    = quote_buy;
         b.last_of_run  = (fill == 0);
         expected_bars.insert(expected_bars.size(), b);
         // fillers carry the previous close and VWAP with empty totals
         b.open_price   = px_close;
         b.high_price   = px_close;
         b.low_price    = px_close;
         b.trade_count  = '0;
         b.volume_total = '0;
         b.volume_buy   = '0;
         b.quote_total  = '0;
         b.quote_buy    = '0;
         for (logic [63:0] k = 1; k <= fill; k++) begin
            b.bar_time    = 48'(bar_start + k * per);
            b.last_of_run = (k == fill);
            expected_bars.insert(expected_bars.size(), b);
         end
         start_new_bar(tr);
      end
      prev_trade_ms = t;
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("bar mismatch on %s: got %0h, expected %0h", field, got, want);
      error_count++;
   endtask

   // Check each bar transfer against the oldest expected bar.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bars.size() == 0) begin
            report_mismatch("bar_time (no bar expected)", 64'(rsp_data.bar_time), '0);
         end else begin
            want = expected_bars.pop_front();
            if (rsp_data.bar_time !== want.bar_time)
               report_mismatch("bar_time", rsp_data.bar_time, want.bar_time);
            if (rsp_data.open_price !== want.open_price)
               report_mismatch("open_price", rsp_data.open_price, want.open_price);
            if (rsp_data.high_price !== want.high_price)
               report_mismatch("high_price", rsp_data.high_price, want.high_price);
            if (rsp_data.low_price !== want.low_price)
               report_mismatch("low_price", rsp_data.low_price, want.low_price);
            if (rsp_data.close_price !== want.close_price)
               report_mismatch("close_price", rsp_data.close_price, want.close_price);
            if (rsp_data.vwap_price !== want.vwap_price)
               report_mismatch("vwap_price", rsp_data.vwap_price, want.vwap_price);
            if (rsp_data.trade_count !== want.trade_count)
               report_mismatch("trade_count", rsp_data.trade_count, want.trade_count);
            if (rsp_data.volume_total !== want.volume_total)
               report_mismatch("volume_total", rsp_data.volume_total, want.volume_total);
            if (rsp_data.volume_buy !== want.volume_buy)
               report_mismatch("volume_buy", rsp_data.volume_buy, want.volume_buy);
            if (rsp_data.quote_total !== want.quote_total)
               report_mismatch("quote_total", rsp_data.quote_total, want.quote_total);
            if (rsp_data.quote_buy !== want.quote_buy)
               report_mismatch("quote_buy", rsp_data.quote_buy, want.quote_buy);
            if (rsp_data.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", rsp_data.last_of_run, want.last_of_run);
         end
      end
   end

   // Receiver: honor a requested long hold first, else cycle through stall patterns
   // (always ready, coin flip, mostly stalled, always ready) in turn as ready_phase advances.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         ready_phase++;
         case ((ready_phase / 50) % 4)
            1: begin
               rsp_ready <= $urandom_range(0, 1);
            end
            2: begin
               rsp_ready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
               rsp_ready <= 1'b1;
            end
         endcase
      end
   end

   // Watchdog: end the run if no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("trade_to_ohlcv_bar_aggregator_unit test failed");
         $finish;
      end
   end

   function automatic req_type make_trade(input logic [63:0] t, input logic [31:0] p,
                                          input logic [31:0] v, input logic [47:0] q,
                                          input logic sell);
      req_type tr;
      tr.trade_time     = t[47:0];
      tr.price          = p;
      tr.volume         = v;
      tr.quote          = q;
      tr.buyer_is_maker = sell;
      return tr;
   endfunction

   // Send one trade: open a new burst after a random gap, hold valid until the transfer.
   task automatic send_trade(input req_type tr);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= tr;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_bars(tr);
   endtask

   // Drop valid and wait for every expected bar; optionally let the block settle.
   task automatic drain(input bit settle);
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_bars.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bar_seconds(input logic [TF_W-1:0] secs);
      drain(1);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= secs;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      bar_seconds = secs;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Send a trade and advance next_time to its time; next_time never moves backward.
   task automatic send_at(input logic [63:0] t, input logic [31:0] p, input logic [31:0] v,
                          input logic [47:0] q, input logic sell);
      send_trade(make_trade(t, p, v, q, sell));
      if (t > next_time) next_time = t;
   endtask

   function automatic logic [47:0] random_quote();
      case ($urandom_range(0, 3))
         0: return 48'($urandom_range(0, 1000));
         1: return {16'($urandom), 32'($urandom)};
         default: return 48'($urandom_range(0, 32'hFFFFF));
      endcase
   endfunction

   // Opening trade at full-scale fields, in-bar extremes, stale and equal-time trades.
   task automatic test_open_and_inbar();
      send_at(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
      send_at(100, 0, 0, 48'hFFFF_FFFF_FFFF, 1'b1);
      send_at(100, 32'h1234_5678, 7, 48'd900, 1'b0);
      send_at(999, 32'h8000_0000, 32'hFFFF_FFFF, 48'd0, 1'b1);
      send_at(50, 32'd5, 32'd5, 48'd5, 1'b0);           // older than the last trade
   endtask

   // Closing trades: no fillers, a few fillers, a run capped at the filler limit,
   // a zero-volume bar and a VWAP that overflows 32 bits.
   task automatic test_bar_close();
      send_at(1000, 32'd10, 0, 48'd5, 1'b1);
      send_at(1500, 32'd11, 0, 48'd7, 1'b0);               // volume still zero: VWAP 0
      send_at(2000, 32'd12, 1, 48'hFFFF_FFFF_FFFF, 1'b0);
      send_at(2001, 32'd13, 0, 48'hFFFF_FFFF_FFFF, 1'b1);  // VWAP saturates
      send_at(7500, 32'd20, 3, 48'd60, 1'b0);
      send_at(200_000, 32'd21, 4, 48'd84, 1'b1);           // beyond the filler cap
      send_at(200_999, 32'd22, 2, 48'd44, 1'b0);
      send_at(202_000, 32'd23, 2, 48'd46, 1'b0);
      drain(0);
   endtask

   // Zero, longest and shortest bar lengths; a length change with a bar open.
   task automatic test_bar_length();
      write_bar_seconds(0);
      send_at(next_time + 1000, 32'd30, 5, 48'd150, 1'b0);
      send_at(next_time + 2500, 32'd31, 5, 48'd155, 1'b1);
      write_bar_seconds(17'd86400);
      send_at(next_time + 1000, 32'd32, 5, 48'd160, 1'b0);
      send_at(next_time + 86_400_000, 32'd33, 5, 48'd165, 1'b0);
      send_at(next_time + 3 * 86_400_000, 32'd34, 5, 48'd170, 1'b1);
      write_bar_seconds(17'h1FFFF);
      send_at(next_time + 200_000_000, 32'd35, 5, 48'd175, 1'b0);
      write_bar_seconds(1);
      send_at(next_time + 5000, 32'd36, 5, 48'd180, 1'b0);
      drain(0);
   endtask

   // Mostly well-formed streams: in-bar runs, period steps and long gaps, with some
   // stale and repeated times mixed in.
   task automatic test_random_stream(input int count);
      logic [63:0] per, t;
      int          pick;
      for (int i = 0; i < count; i++) begin
         if (i % 35 == 0)
            write_bar_seconds((i % 70 == 0) ? TF_W'($urandom_range(1, 3))
                                            : TF_W'($urandom_range(0, 17'h1FFFF)));
         per  = bar_length_ms();
         pick = $urandom_range(0, 99);
         if (pick < 60)      t = next_time + $urandom_range(0, 32'(per / 4));
         else if (pick < 80) t = next_time + per * $urandom_range(1, 3);
         else if (pick < 87) t = next_time + per * $urandom_range(4, 80);
         else if (pick < 94) t = (next_time > 10) ? next_time - $urandom_range(1, 10) : 0;
         else                t = next_time;
         send_at(t, (pick % 3 == 0) ? $urandom : $urandom_range(90, 110),
                 (pick % 4 == 0) ? $urandom : $urandom_range(0, 50),
                 random_quote(), $urandom_range(0, 1));
      end
      drain(0);
   endtask

   // Hold the receiver off while trades keep coming so the block stalls its input,
   // then pause the sender until every bar has arrived.
   task automatic test_backpressure();
      hold_request = 600;
      for (int i = 0; i < 12; i++)
         send_at(next_time + 1000 * $urandom_range(1, 6), $urandom, $urandom_range(1, 9),
                 random_quote(), $urandom_range(0, 1));
      drain(0);
      for (int i = 0; i < 4; i++)
         send_at(next_time + 1000, $urandom, $urandom_range(1, 9), random_quote(), 1'b0);
      drain(0);
   endtask

   // Drive the trade time up to its top value with a bar length of 86400 seconds.
   task automatic test_time_top();
      write_bar_seconds(17'd86400);
      send_at(TIME_MAX - 3 * 64'd86_400_000, 32'd40, 3, 48'd120, 1'b0);
      send_at(TIME_MAX, 32'd41, 3, 48'd123, 1'b1);
      send_at(TIME_MAX, 32'd42, 3, 48'd126, 1'b0);
      drain(0);
   endtask

   initial begin
      bar_seconds     = TF_W'(1);
      bar_is_open     = 1'b0;
      prev_trade_ms   = '0;
      bar_start       = '0;
      {px_open, px_high, px_low, px_close, px_vwap, trade_cnt} = '0;
      {vol_total, vol_buy, quote_total, quote_buy} = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_open_and_inbar();
      test_bar_close();
      test_bar_length();
      test_random_stream(60);
      test_backpressure();
      test_time_top();

      drain(1);
      if (error_count == 0)
         $display("trade_to_ohlcv_bar_aggregator_unit test passed");
      else
         $display("trade_to_ohlcv_bar_aggregator_unit test failed");
      $finish;
   end

endmodule
